[hdl/least_squares_trend_slope_defines.svh]
// Assertion helpers shared by the trend slope RTL.
// Each use expects clk and rst_n in scope and stands on a line of its own.
`ifndef LEAST_SQUARES_TREND_SLOPE_DEFINES_SVH
`define LEAST_SQUARES_TREND_SLOPE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lsts_pkg.sv]
`default_nettype none

package lsts_pkg;

  localparam int CHANNELS    = 3;
  localparam int MAX_WINDOW  = 1023;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 8;

  // port field widths
  localparam int CH_W     = 2;
  localparam int SAMPLE_W = 24;
  localparam int SLOPE_W  = 32;
  localparam int CODE_W   = 2;
  localparam int WIN_W    = 10;

  // per-channel state widths
  localparam int IDX_W = 11;
  localparam int SA_W  = 20;
  localparam int SB_W  = 34;
  localparam int SC_W  = 44;
  localparam int SD_W  = 30;

  localparam int WIN_RESET = 50;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // serial datapath widths
  localparam int ACC_W = 56;                        // numerator and denominator
  localparam int MPL_W = (SA_W > IDX_W) ? SA_W : IDX_W;
  localparam int XW    = ACC_W + FRAC_BITS;         // scaled dividend
  localparam int QB    = SLOPE_W - 1;               // quotient magnitude bits
  localparam int CNT_W = $clog2(QB + 1);

  localparam logic [SLOPE_W-1:0] SAT_POS = {1'b0, {QB{1'b1}}};
  localparam logic [SLOPE_W-1:0] SAT_NEG = {1'b1, {QB{1'b0}}};

  typedef enum logic [CODE_W-1:0] {
    DIR_RISE = 2'd0,
    DIR_FALL = 2'd1,
    DIR_FLAT = 2'd2
  } dir_t;

  typedef enum logic [CODE_W-1:0] {
    STAT_VALID    = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_CLEARED  = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_UPD,
    S_MUL2,
    S_LOAD3,
    S_MUL3,
    S_DSTART,
    S_DIV,
    S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_PREP,
    D_RUN,
    D_DONE
  } div_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic sub;
    logic step;
  } mul_ctl_t;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    dir_t               direction;
    stat_t              status;
  } div_res_t;

endpackage

`default_nettype wire

[hdl/lsts_chan_if.sv]
`default_nettype none

interface lsts_in_if import lsts_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, channel, sample, input ready);
  modport sink (input valid, channel, sample, output ready);
endinterface

interface lsts_out_if import lsts_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CH_W-1:0]           channel_out;
  logic signed [SLOPE_W-1:0] slope;
  logic [CODE_W-1:0]         direction;
  logic [CODE_W-1:0]         status;

  modport source (output valid, channel_out, slope, direction, status, input ready);
  modport sink (input valid, channel_out, slope, direction, status, output ready);
endinterface

`default_nettype wire

[hdl/lsts_mul.sv]
`default_nettype none

// Two shift-add lanes that share one multiplier, one multiplier bit per step.
module lsts_mul import lsts_pkg::*; (
  input  logic                    clk,
  input  mul_ctl_t                ctl,
  input  logic signed [ACC_W-1:0] mcand_n,
  input  logic signed [ACC_W-1:0] mcand_d,
  input  logic [MPL_W-1:0]        mplier,
  output logic signed [ACC_W-1:0] acc_n,
  output logic signed [ACC_W-1:0] acc_d
);

  logic [ACC_W-1:0] mcn_r, mcd_r;
  logic [ACC_W-1:0] accn_r, accd_r;
  logic [ACC_W-1:0] accn_nxt, accd_nxt;
  logic [ACC_W-1:0] addn, addd;
  logic [MPL_W-1:0] mpl_r;
  logic             sub_r;

  always_comb begin
    addn = mpl_r[0] ? mcn_r : '0;
    addd = mpl_r[0] ? mcd_r : '0;
    accn_nxt = sub_r ? accn_r - addn : accn_r + addn;
    accd_nxt = sub_r ? accd_r - addd : accd_r + addd;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcn_r <= mcand_n;
      mcd_r <= mcand_d;
      mpl_r <= mplier;
      sub_r <= ctl.sub;
      if (ctl.clear) begin
        accn_r <= '0;
        accd_r <= '0;
      end
    end else if (ctl.step) begin
      accn_r <= accn_nxt;
      accd_r <= accd_nxt;
      mcn_r  <= mcn_r << 1;
      mcd_r  <= mcd_r << 1;
      mpl_r  <= mpl_r >> 1;
    end
  end

  assign acc_n = accn_r;
  assign acc_d = accd_r;

endmodule

`default_nettype wire

[hdl/lsts_div.sv]
`default_nettype none

`include "least_squares_trend_slope_defines.svh"

// Signed fixed-point divide: one quotient bit per cycle, saturating.
module lsts_div import lsts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic signed [ACC_W-1:0] den,
  output logic                    done,
  output div_res_t                res
);

  div_state_t         dstate_r, dstate_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic [ACC_W-1:0]   un_r, ud_r, rem_r;
  logic [QB-1:0]      xlo_r, q_r;
  div_res_t           res_r;

  logic [ACC_W-1:0]   num_u, den_u, num_mag, den_mag;
  logic [XW-1:0]      x;
  logic [ACC_W-1:0]   xhi_ext;
  logic               sat;
  logic [ACC_W:0]     t, t_sub, ud_ext;
  logic               ge;
  logic [QB-1:0]      q_fin;
  logic [SLOPE_W-1:0] mag_ext;
  dir_t               dir;

  always_comb begin
    num_u   = num;
    den_u   = den;
    num_mag = num[ACC_W-1] ? (~num_u + 1'b1) : num_u;
    den_mag = den[ACC_W-1] ? (~den_u + 1'b1) : den_u;
    x       = XW'(un_r) << FRAC_BITS;
    xhi_ext = ACC_W'(x[XW-1:QB]);
    // integer part already too big for the slope field
    sat     = xhi_ext >= ud_r;
    dir     = (un_r == '0) ? DIR_FLAT : (neg_r ? DIR_FALL : DIR_RISE);
    t       = {rem_r, xlo_r[QB-1]};
    ud_ext  = {1'b0, ud_r};
    ge      = t >= ud_ext;
    t_sub   = t - ud_ext;
    q_fin   = {q_r[QB-2:0], ge};
    mag_ext = {1'b0, q_fin};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
    end else begin
      dstate_r <= dstate_nxt;
    end
  end

  always_comb begin
    dstate_nxt = dstate_r;
    case (dstate_r)
      D_IDLE: begin
        if (start) dstate_nxt = D_PREP;
      end
      D_PREP: begin
        if (ud_r == '0 || sat) dstate_nxt = D_DONE;
        else                   dstate_nxt = D_RUN;
      end
      D_RUN: begin
        if (cnt_r == '0) dstate_nxt = D_DONE;
      end
      D_DONE: begin
        dstate_nxt = D_IDLE;
      end
      default: dstate_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (dstate_r)
      D_IDLE: begin
        if (start) begin
          un_r  <= num_mag;
          ud_r  <= den_mag;
          neg_r <= num[ACC_W-1] ^ den[ACC_W-1];
        end
      end
      D_PREP: begin
        if (ud_r == '0) begin
          res_r.slope     <= '0;
          res_r.direction <= DIR_FLAT;
          res_r.status    <= STAT_ZERO_DEN;
        end else begin
          res_r.direction <= dir;
          res_r.status    <= STAT_VALID;
          res_r.slope     <= neg_r ? SAT_NEG : SAT_POS;
          rem_r           <= xhi_ext;
          xlo_r           <= x[QB-1:0];
          cnt_r           <= CNT_W'(QB - 1);
        end
      end
      D_RUN: begin
        // restoring step: bring down the next dividend bit
        rem_r <= ge ? t_sub[ACC_W-1:0] : t[ACC_W-1:0];
        q_r   <= q_fin;
        xlo_r <= xlo_r << 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_r.slope <= neg_r ? (SLOPE_W'(0) - mag_ext) : mag_ext;
        end
      end
      default: begin
      end
    endcase
  end

  assign done = (dstate_r == D_DONE);
  assign res  = res_r;

  `LSTS_ASSERT_NOW(a_div_start_idle, start, dstate_r == D_IDLE, "divider started while busy")
  `LSTS_ASSERT_NOW(a_div_flat_zero, done && res.status == STAT_VALID && res.direction == DIR_FLAT, res.slope == '0, "flat trend with nonzero slope")
  `LSTS_ASSERT_NOW(a_div_zero_den, done && res.status == STAT_ZERO_DEN, res.slope == '0 && res.direction == DIR_FLAT, "zero denominator result not cleared")

endmodule

`default_nettype wire

[hdl/least_squares_trend_slope.sv]
// Running least-squares trend slope for up to three sensor channels.
// Input channel in_chan (valid/ready): channel number and a signed sample.
// Result channel out_chan (valid/ready): channel, slope with 8 fraction bits
// (saturated), direction (rising, falling, flat) and status.
// cfg_we/cfg_wdata set the window length; write only while the block is idle.
// Each item for a used channel yields exactly one result; an item for an
// unused channel number is taken and yields none. A sample that reaches the
// window clears its channel and returns a cleared status without a divide.
// A counted sample runs three serial shift-add passes of 11, 11 and 20 steps
// through one two-lane multiplier, then a 31-step restoring divider whose
// steps are skipped when the quotient saturates or the denominator is zero;
// load, start and handoff states come in between.
// One item is in flight at a time; in_chan.ready is high only between items,
// so no new item is taken until the last result is in the output register.
// A finished result sits in the output register, so the next item is taken
// while the receiver stalls; a second result waits until that register frees.
// Synchronous reset sets every channel index to 1, clears all sums and sets
// the window length to 50.
`default_nettype none

`include "least_squares_trend_slope_defines.svh"

module least_squares_trend_slope import lsts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  lsts_in_if.sink          in_chan,
  lsts_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata
);

  seq_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIN_W-1:0] win_len_r;

  logic [IDX_W-1:0] idx_r [CHANNELS];
  logic [SA_W-1:0]  sa_r  [CHANNELS];
  logic [SB_W-1:0]  sb_r  [CHANNELS];
  logic [SC_W-1:0]  sc_r  [CHANNELS];
  logic [SD_W-1:0]  sd_r  [CHANNELS];

  logic [CH_W-1:0]        ch_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [IDX_W-1:0]       n_r;
  div_res_t               res_r;

  logic                   out_valid_r;
  logic [CH_W-1:0]        out_ch_r;
  div_res_t               out_res_r;

  logic [CH_IDX_W-1:0]    in_ci, ci;
  logic                   accept, in_ch_ok, win_hit, clr_en, upd_en, out_load;
  logic [IDX_W-1:0]       in_n, win_use;
  logic [SA_W-1:0]        a_new;
  logic [SB_W-1:0]        b_new;
  logic [SC_W-1:0]        c_new;
  logic [SD_W-1:0]        d_new;

  mul_ctl_t                mul_ctl;
  logic signed [ACC_W-1:0] mcand_n, mcand_d, acc_n, acc_d;
  logic [MPL_W-1:0]        mplier;
  logic                    div_start, div_done;
  div_res_t                div_res;

  lsts_mul u_mul (
    .clk     (clk),
    .ctl     (mul_ctl),
    .mcand_n (mcand_n),
    .mcand_d (mcand_d),
    .mplier  (mplier),
    .acc_n   (acc_n),
    .acc_d   (acc_d)
  );

  lsts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_n),
    .den   (acc_d),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    in_ci    = in_chan.channel[CH_IDX_W-1:0];
    ci       = ch_r[CH_IDX_W-1:0];
    in_ch_ok = int'(in_chan.channel) < CHANNELS;
    in_n     = in_ch_ok ? idx_r[in_ci] : IDX_W'(1);
    win_use  = (int'(win_len_r) > MAX_WINDOW) ? IDX_W'(MAX_WINDOW) : IDX_W'(win_len_r);
    win_hit  = in_n >= win_use;
    accept   = in_chan.valid && in_chan.ready;
    clr_en   = accept && in_ch_ok && win_hit;
    upd_en   = (state_r == S_UPD);
    out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

    a_new = sa_r[ci] + SA_W'(n_r);
    b_new = sb_r[ci] + {{(SB_W-SAMPLE_BITS){smp_r[SAMPLE_BITS-1]}}, smp_r};
    c_new = sc_r[ci] + acc_n[SC_W-1:0];
    d_new = sd_r[ci] + acc_d[SD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_chan.ready = 1'b0;
    mul_ctl       = '0;
    mcand_n       = '0;
    mcand_d       = '0;
    mplier        = '0;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        // first pass: sample times index and index squared
        mul_ctl.load  = 1'b1;
        mul_ctl.clear = 1'b1;
        mcand_n = {{(ACC_W-SAMPLE_BITS){in_chan.sample[SAMPLE_BITS-1]}},
                   in_chan.sample[SAMPLE_BITS-1:0]};
        mcand_d = ACC_W'(in_n);
        mplier  = MPL_W'(in_n);
        if (accept && in_ch_ok) begin
          if (win_hit) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_MUL1;
            cnt_nxt   = CNT_W'(IDX_W - 1);
          end
        end
      end
      S_MUL1, S_MUL2, S_MUL3: begin
        mul_ctl.step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          case (state_r)
            S_MUL1:  state_nxt = S_UPD;
            S_MUL2:  state_nxt = S_LOAD3;
            default: state_nxt = S_DSTART;
          endcase
        end
      end
      S_UPD: begin
        // second pass: n*C and n*D on the updated sums
        mul_ctl.load  = 1'b1;
        mul_ctl.clear = 1'b1;
        mcand_n   = {{(ACC_W-SC_W){c_new[SC_W-1]}}, c_new};
        mcand_d   = ACC_W'(d_new);
        mplier    = MPL_W'(n_r);
        cnt_nxt   = CNT_W'(IDX_W - 1);
        state_nxt = S_MUL2;
      end
      S_LOAD3: begin
        // third pass: subtract A*B and A*A
        mul_ctl.load = 1'b1;
        mul_ctl.sub  = 1'b1;
        mcand_n   = {{(ACC_W-SB_W){sb_r[ci][SB_W-1]}}, sb_r[ci]};
        mcand_d   = ACC_W'(sa_r[ci]);
        mplier    = MPL_W'(sa_r[ci]);
        cnt_nxt   = CNT_W'(MPL_W - 1);
        state_nxt = S_MUL3;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (accept) begin
      ch_r  <= in_chan.channel;
      smp_r <= in_chan.sample[SAMPLE_BITS-1:0];
      n_r   <= in_n;
    end
    if (clr_en) begin
      res_r.slope     <= '0;
      res_r.direction <= DIR_FLAT;
      res_r.status    <= STAT_CLEARED;
    end else if (state_r == S_DIV && div_done) begin
      res_r <= div_res;
    end
    if (out_load) begin
      out_ch_r  <= ch_r;
      out_res_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= WIN_W'(WIN_RESET);
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        idx_r[c] <= IDX_W'(1);
        sa_r[c]  <= '0;
        sb_r[c]  <= '0;
        sc_r[c]  <= '0;
        sd_r[c]  <= '0;
      end
    end else begin
      if (cfg_we) win_len_r <= cfg_wdata;
      if (out_load)            out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
      if (clr_en) begin
        // window reached: restart the channel and drop the sample
        idx_r[in_ci] <= IDX_W'(1);
        sa_r[in_ci]  <= '0;
        sb_r[in_ci]  <= '0;
        sc_r[in_ci]  <= '0;
        sd_r[in_ci]  <= '0;
      end else if (upd_en) begin
        idx_r[ci] <= n_r + 1'b1;
        sa_r[ci]  <= a_new;
        sb_r[ci]  <= b_new;
        sc_r[ci]  <= c_new;
        sd_r[ci]  <= d_new;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.channel_out = out_ch_r;
  assign out_chan.slope       = out_res_r.slope;
  assign out_chan.direction   = out_res_r.direction;
  assign out_chan.status      = out_res_r.status;

  `LSTS_ASSERT_NOW(a_done_in_div, div_done, state_r == S_DIV, "divider result outside wait state")
  `LSTS_ASSERT_NEXT(a_accept_leaves_idle, accept && in_ch_ok, state_r != S_IDLE, "valid item left sequencer idle")
  `LSTS_ASSERT_NEXT(a_out_loaded, out_load, out_valid_r && state_r == S_IDLE, "result not presented after load")

endmodule

`default_nettype wire
